@@ hw/rtl/dereg_pkg.sv @@
`default_nettype none

package dereg_pkg;

    // data widths
    localparam int SAMPLE_W   = 17;
    localparam int ERR_W      = 18;
    localparam int OUT_W      = 16;
    localparam int COEF_W     = 18;
    localparam int ACC_W      = 40;
    localparam int COEF_FRAC  = 12;
    localparam int ROUND_W    = ACC_W - COEF_FRAC;
    localparam int ERR_TAPS   = 6;
    localparam int ERR_DEPTH  = ERR_TAPS - 1;
    localparam int OUT_TAPS   = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SAT_LOW  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_SAT_HIGH = t_cfg_idx'(1);

    localparam logic signed [OUT_W-1:0] SAT_LOW_RST  = -16'sd15360;
    localparam logic signed [OUT_W-1:0] SAT_HIGH_RST = 16'sd15360;

    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic signed [OUT_W-1:0]  t_out;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // output clamp limits
    typedef struct packed {
        t_out sat_low;
        t_out sat_high;
    } t_limits;

    // error tap coefficients in Q6.12, index 0 multiplies the newest error
    localparam t_coef ERR_COEF [ERR_TAPS] = '{
        -18'sd135, 18'sd3154, -18'sd22528, 18'sd68280, -18'sd95560, 18'sd45507
    };

    // output tap coefficients in Q6.12, index 0 multiplies the last output
    localparam t_coef OUT_COEF [OUT_TAPS] = '{
        -18'sd15483, 18'sd18186, 18'sd17490, -18'sd13652
    };

    localparam t_acc ROUND_HALF = t_acc'(1) <<< (COEF_FRAC - 1);

endpackage

`default_nettype wire

@@ hw/rtl/dereg_cfg_regs.sv @@
`default_nettype none

module dereg_cfg_regs
    import dereg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire t_cfg_idx              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_limits                    o_limits
);

    t_limits r_limits;
    t_limits n_limits;

    // decode the register write, unknown indexes are dropped
    always_comb begin
        n_limits = r_limits;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAT_LOW:  n_limits.sat_low  = t_out'(i_cfg_data);
                REG_SAT_HIGH: n_limits.sat_high = t_out'(i_cfg_data);
                default:      n_limits = r_limits;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.sat_low  <= SAT_LOW_RST;
            r_limits.sat_high <= SAT_HIGH_RST;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

`default_nettype wire

@@ hw/rtl/dereg_filter.sv @@
`default_nettype none

module dereg_filter
    import dereg_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire t_limits                    i_limits,
    output t_out                            o_result
);

    t_err r_err_hist [ERR_DEPTH];
    t_out r_out_hist [OUT_TAPS];

    t_err                       e0;
    t_acc                       err_prod [ERR_TAPS];
    t_acc                       out_prod [OUT_TAPS];
    t_acc                       sum;
    logic signed [ROUND_W-1:0]  rounded;
    logic signed [ROUND_W-1:0]  clamped;

    // newest error, set point is zero
    assign e0 = -t_err'(i_sample);

    // constant-coefficient taps
    always_comb begin
        err_prod[0] = t_acc'(e0) * t_acc'(ERR_COEF[0]);
        for (int k = 1; k < ERR_TAPS; k++) begin
            err_prod[k] = t_acc'(r_err_hist[k-1]) * t_acc'(ERR_COEF[k]);
        end
        for (int k = 0; k < OUT_TAPS; k++) begin
            out_prod[k] = t_acc'(r_out_hist[k]) * t_acc'(OUT_COEF[k]);
        end
    end

    // sum of all taps
    always_comb begin
        sum = '0;
        for (int k = 0; k < ERR_TAPS; k++) begin
            sum = sum + err_prod[k];
        end
        for (int k = 0; k < OUT_TAPS; k++) begin
            sum = sum + out_prod[k];
        end
    end

    // round half up, then clamp high first and low last
    always_comb begin
        rounded = ROUND_W'((sum + ROUND_HALF) >>> COEF_FRAC);
        clamped = rounded;
        if (clamped > ROUND_W'(i_limits.sat_high)) begin
            clamped = ROUND_W'(i_limits.sat_high);
        end
        if (clamped < ROUND_W'(i_limits.sat_low)) begin
            clamped = ROUND_W'(i_limits.sat_low);
        end
    end

    assign o_result = t_out'(clamped);

    // history shift on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ERR_DEPTH; k++) begin
                r_err_hist[k] <= '0;
            end
            for (int k = 0; k < OUT_TAPS; k++) begin
                r_out_hist[k] <= '0;
            end
        end else if (i_advance) begin
            r_err_hist[0] <= e0;
            for (int k = 1; k < ERR_DEPTH; k++) begin
                r_err_hist[k] <= r_err_hist[k-1];
            end
            r_out_hist[0] <= o_result;
            for (int k = 1; k < OUT_TAPS; k++) begin
                r_out_hist[k] <= r_out_hist[k-1];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/difference_equation_regulator.sv @@
`default_nettype none

// datapath: the sample is registered in r_sample and the filter result in
//   r_drive, which drive_offset presents while o_out_valid is set
// throughput: one sample per cycle while the output is not stalled; the output
//   feedback closes through the history registers over the combinational tap/round/clamp path
// reset: synchronous active low; clears both valid flags and all error and
//   output history, sets the clamp limits to -60.0 and +60.0 in Q8.8
module difference_equation_regulator
    import dereg_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0]  i_accel_sample,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [OUT_W-1:0]          o_drive_offset,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data
);

    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_out_valid;
    t_out                       r_drive;

    logic    advance;
    logic    in_take;
    t_out    result;
    t_limits limits;

    // the sample register moves on whenever the output slot is free or leaving
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    dereg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    // filter datapath and history
    dereg_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_sample  (r_sample),
        .i_limits  (limits),
        .o_result  (result)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_accel_sample;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_offset = r_drive;

    // a stalled sample only waits behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // every processed sample shows up as a result next cycle
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_out_valid && o_drive_offset == $past(result)))
        else $error("processed sample not presented");

    // reset empties the input register and the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("valid flags survived reset");

endmodule

`default_nettype wire
